@@ hdl/postfix_regex_to_nfa_builder_core_defines.svh @@
// Assertion macros shared by the NFA builder modules.
`ifndef POSTFIX_REGEX_TO_NFA_BUILDER_CORE_DEFINES_SVH
`define POSTFIX_REGEX_TO_NFA_BUILDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define PRN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prnfa assertion failed");
// Checked at every edge, reset included.
`define PRN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prnfa assertion failed");
`else
`define PRN_ASSERT(lbl, clk, rst_n, prop)
`define PRN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/prnfa_pkg.sv @@
package prnfa_pkg;

  // Sizing
  localparam int FRAG_DEPTH = 16;
  localparam int MAX_STATES = 256;
  localparam int SNUM_W     = $clog2(MAX_STATES);
  localparam int CNT_W      = $clog2(FRAG_DEPTH + 1);
  localparam int CTR_W      = $clog2(MAX_STATES + 1);
  localparam int CTR_X_W    = CTR_W + 1;
  localparam int RUN_LEN    = 4;

  // Label carried on epsilon edges ('e')
  localparam logic [7:0] EPS_LABEL = 8'h65;

  // Token kind codes on the input port
  localparam logic [2:0] KIND_SYM  = 3'd0;
  localparam logic [2:0] KIND_ALT  = 3'd1;
  localparam logic [2:0] KIND_CAT  = 3'd2;
  localparam logic [2:0] KIND_STAR = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_EXHAUSTED = 2'd3;

  typedef enum logic [2:0] {
    OP_SYM,
    OP_ALT,
    OP_CAT,
    OP_STAR,
    OP_END
  } op_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_TOP
  } stk_op_t;

  // Classified token word between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] symbol;
  } tok_t;

  // One result word
  typedef struct packed {
    logic [7:0] from_state;
    logic [7:0] to_state;
    logic [7:0] edge_symbol;
    logic       is_epsilon;
    logic       is_final_report;
    logic [4:0] fragments_left;
    logic [1:0] error_code;
    logic       last_of_run;
  } res_t;

endpackage

@@ hdl/prnfa_front.sv @@
`include "postfix_regex_to_nfa_builder_core_defines.svh"

module prnfa_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_token_kind,
  input  logic [7:0]      in_symbol,
  output logic            tok_valid,
  input  logic            tok_ready,
  output prnfa_pkg::tok_t tok
);
  import prnfa_pkg::*;

  tok_t       q_r [2];
  logic       q_wp_r;
  logic       q_rp_r;
  logic [1:0] q_cnt_r;
  logic       known;
  op_t        op;
  logic       push;
  logic       pop;

  // Classify the token; unknown kinds are dropped here
  always_comb begin
    known = 1'b1;
    op    = OP_SYM;
    unique case (in_token_kind)
      KIND_SYM:  op = OP_SYM;
      KIND_ALT:  op = OP_ALT;
      KIND_CAT:  op = OP_CAT;
      KIND_STAR: op = OP_STAR;
      KIND_END:  op = OP_END;
      default:   known = 1'b0;
    endcase
  end

  assign in_ready  = (q_cnt_r != 2'd2);
  assign tok_valid = (q_cnt_r != 2'd0);
  assign tok       = q_r[q_rp_r];
  assign push      = in_valid && in_ready && known;
  assign pop       = tok_valid && tok_ready;

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop)  q_rp_r <= ~q_rp_r;
      unique case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[q_wp_r] <= '{op: op, symbol: in_symbol};
  end

  `PRN_ASSERT(a_q_bound, clk, rst_n, q_cnt_r <= 2'd2)
  `PRN_ASSERT(a_q_push_seen, clk, rst_n, (push && q_cnt_r == 2'd0) |=> tok_valid)
  `PRN_ASSERT_ALWAYS(a_q_rst_empty, clk, !rst_n |=> (q_cnt_r == 2'd0 && !tok_valid))

endmodule

@@ hdl/prnfa_back.sv @@
`include "postfix_regex_to_nfa_builder_core_defines.svh"

module prnfa_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  output logic            tok_ready,
  input  prnfa_pkg::tok_t tok,
  output logic            out_valid,
  input  logic            out_ready,
  output prnfa_pkg::res_t out_res
);
  import prnfa_pkg::*;

  // Fragment stack, top at entry 0
  logic [SNUM_W-1:0] stk_start_r  [FRAG_DEPTH];
  logic [SNUM_W-1:0] stk_accept_r [FRAG_DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CTR_W-1:0]  nxt_r, nxt_nxt;

  // Result run buffer and output register
  res_t              run_r [RUN_LEN];
  res_t              run_nxt [RUN_LEN];
  logic [2:0]        left_r, left_nxt;
  logic [1:0]        idx_r, idx_nxt;
  res_t              out_r;
  logic              out_valid_r;

  logic              take;
  logic              out_load;
  logic              room;
  logic [SNUM_W-1:0] s_num, l_num;
  logic [SNUM_W-1:0] top_s, top_a, sec_s, sec_a;
  logic [SNUM_W-1:0] new_s, new_a;
  stk_op_t           stk_op;

  function automatic res_t mk_edge(logic [SNUM_W-1:0] f, logic [SNUM_W-1:0] t,
                                   logic [7:0] sym, logic eps, logic last);
    res_t r;
    r             = '0;
    r.from_state  = 8'(f);
    r.to_state    = 8'(t);
    r.edge_symbol = sym;
    r.is_epsilon  = eps;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic res_t mk_err(logic [1:0] code);
    res_t r;
    r             = '0;
    r.error_code  = code;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  assign top_s    = stk_start_r[0];
  assign top_a    = stk_accept_r[0];
  assign sec_s    = stk_start_r[1];
  assign sec_a    = stk_accept_r[1];
  assign s_num    = nxt_r[SNUM_W-1:0];
  assign l_num    = s_num + SNUM_W'(1);
  assign room     = (CTR_X_W'(nxt_r) + CTR_X_W'(2)) <= CTR_X_W'(MAX_STATES);
  assign out_load = (left_r != 3'd0) && (!out_valid_r || out_ready);
  assign tok_ready = (left_r == 3'd0) || (left_r == 3'd1 && out_load);
  assign take     = tok_valid && tok_ready;

  // Execute a token: build its run of results and the stack update
  always_comb begin
    run_nxt  = run_r;
    left_nxt = left_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    nxt_nxt  = nxt_r;
    stk_op   = STK_HOLD;
    new_s    = s_num;
    new_a    = l_num;
    if (out_load) begin
      left_nxt = left_r - 3'd1;
      idx_nxt  = idx_r + 2'd1;
    end
    if (take) begin
      idx_nxt    = 2'd0;
      left_nxt   = 3'd1;
      run_nxt[0] = mk_err(ERR_UNDERFLOW);
      unique case (tok.op)
        OP_SYM: begin
          if (cnt_r == CNT_W'(FRAG_DEPTH)) begin
            run_nxt[0] = mk_err(ERR_OVERFLOW);
          end else if (!room) begin
            run_nxt[0] = mk_err(ERR_EXHAUSTED);
          end else begin
            run_nxt[0] = mk_edge(s_num, l_num, tok.symbol, 1'b0, 1'b1);
            stk_op     = STK_PUSH;
            cnt_nxt    = cnt_r + CNT_W'(1);
            nxt_nxt    = nxt_r + CTR_W'(2);
          end
        end
        OP_ALT: begin
          if (cnt_r < CNT_W'(2)) begin
            run_nxt[0] = mk_err(ERR_UNDERFLOW);
          end else if (!room) begin
            run_nxt[0] = mk_err(ERR_EXHAUSTED);
          end else begin
            run_nxt[0] = mk_edge(s_num, top_s, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[1] = mk_edge(s_num, sec_s, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[2] = mk_edge(top_a, l_num, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[3] = mk_edge(sec_a, l_num, EPS_LABEL, 1'b1, 1'b1);
            left_nxt   = 3'd4;
            stk_op     = STK_POP;
            cnt_nxt    = cnt_r - CNT_W'(1);
            nxt_nxt    = nxt_r + CTR_W'(2);
          end
        end
        OP_CAT: begin
          if (cnt_r < CNT_W'(2)) begin
            run_nxt[0] = mk_err(ERR_UNDERFLOW);
          end else begin
            run_nxt[0] = mk_edge(sec_a, top_s, EPS_LABEL, 1'b1, 1'b1);
            stk_op     = STK_POP;
            new_s      = sec_s;
            new_a      = top_a;
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
        end
        OP_STAR: begin
          if (cnt_r == CNT_W'(0)) begin
            run_nxt[0] = mk_err(ERR_UNDERFLOW);
          end else if (!room) begin
            run_nxt[0] = mk_err(ERR_EXHAUSTED);
          end else begin
            run_nxt[0] = mk_edge(s_num, top_s, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[1] = mk_edge(s_num, l_num, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[2] = mk_edge(top_a, top_s, EPS_LABEL, 1'b1, 1'b0);
            run_nxt[3] = mk_edge(top_a, l_num, EPS_LABEL, 1'b1, 1'b1);
            left_nxt   = 3'd4;
            stk_op     = STK_TOP;
            nxt_nxt    = nxt_r + CTR_W'(2);
          end
        end
        OP_END: begin
          if (cnt_r == CNT_W'(0)) begin
            run_nxt[0] = mk_err(ERR_UNDERFLOW);
          end else begin
            run_nxt[0]                 = mk_edge(top_s, top_a, 8'd0, 1'b0, 1'b1);
            run_nxt[0].is_final_report = 1'b1;
            run_nxt[0].fragments_left  = 5'(cnt_r);
            cnt_nxt                    = '0;
            nxt_nxt                    = '0;
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nxt_r       <= '0;
      left_r      <= 3'd0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      nxt_r  <= nxt_nxt;
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: run buffer, output word, fragment stack
  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    if (out_load) out_r <= run_r[idx_r];
    unique case (stk_op)
      STK_HOLD: ;
      STK_PUSH: begin
        for (int i = 1; i < FRAG_DEPTH; i++) begin
          stk_start_r[i]  <= stk_start_r[i-1];
          stk_accept_r[i] <= stk_accept_r[i-1];
        end
        stk_start_r[0]  <= new_s;
        stk_accept_r[0] <= new_a;
      end
      STK_POP: begin
        for (int i = 1; i < FRAG_DEPTH - 1; i++) begin
          stk_start_r[i]  <= stk_start_r[i+1];
          stk_accept_r[i] <= stk_accept_r[i+1];
        end
        stk_start_r[0]  <= new_s;
        stk_accept_r[0] <= new_a;
      end
      STK_TOP: begin
        stk_start_r[0]  <= new_s;
        stk_accept_r[0] <= new_a;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `PRN_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(FRAG_DEPTH))
  `PRN_ASSERT(a_end_clears, clk, rst_n, (take && tok.op == OP_END && cnt_r != '0) |=> (cnt_r == '0 && nxt_r == '0))
  `PRN_ASSERT(a_run_last, clk, rst_n, (out_load && left_r == 3'd1) |=> (out_valid_r && out_r.last_of_run))

endmodule

@@ hdl/postfix_regex_to_nfa_builder_core.sv @@
// Postfix regular expression to Thompson epsilon-NFA builder.
// Input channel (in_valid/in_ready): one token word per handshake, kind and
// symbol. Kinds 5 to 7 are taken and dropped without any result.
// Output channel (out_valid/out_ready): one transition, final report or error
// word per handshake; last_of_run marks the last word of a token.
// With the back end idle, the first word of a token passes the queue entry,
// the run buffer and the output register in turn. Throughput: one output word
// per cycle while out_ready is high, so symbol, concatenation and end tokens
// run at one per cycle; a built alternation or star gives four words. The output
// register, loaded from a 4-word run buffer, sets this rate.
// A 2-word token queue sits between the classifying front and the executing
// back, so input acceptance continues while the back end drains a run.
// Reset (rst_n low, synchronous) empties the queue, the fragment stack and the
// state counter, and drops any pending output word.
// When the receiver stalls, the current word holds on the outputs, the run
// buffer and queue fill, and in_ready falls once the queue is full.
module postfix_regex_to_nfa_builder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_token_kind,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_from_state,
  output logic [7:0] out_to_state,
  output logic [7:0] out_edge_symbol,
  output logic       out_is_epsilon,
  output logic       out_is_final_report,
  output logic [4:0] out_fragments_left,
  output logic [1:0] out_error_code,
  output logic       out_last_of_run
);
  import prnfa_pkg::*;

  tok_t tok;
  logic tok_valid;
  logic tok_ready;
  res_t res;

  prnfa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_token_kind (in_token_kind),
    .in_symbol     (in_symbol),
    .tok_valid     (tok_valid),
    .tok_ready     (tok_ready),
    .tok           (tok)
  );

  prnfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Split the result word onto its ports
  assign out_from_state      = res.from_state;
  assign out_to_state        = res.to_state;
  assign out_edge_symbol     = res.edge_symbol;
  assign out_is_epsilon      = res.is_epsilon;
  assign out_is_final_report = res.is_final_report;
  assign out_fragments_left  = res.fragments_left;
  assign out_error_code      = res.error_code;
  assign out_last_of_run     = res.last_of_run;

endmodule

@@ sim/postfix_regex_to_nfa_builder_core_tb.sv @@
`timescale 1ns / 1ps

module postfix_regex_to_nfa_builder_core_tb;
  import prnfa_pkg::*;

  localparam int TOKEN_TARGET   = 370;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_SHOWN      = 10;

  localparam logic [7:0] CH_E    = 8'h65;  // 'e'
  localparam logic [7:0] CH_A    = 8'h61;  // 'a'
  localparam logic [7:0] CH_B    = 8'h62;  // 'b'
  localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'
  localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

  // Thompson builder mirror plus the queue of NFA words it still owes
  class nfa_scoreboard;
    int   frag_start[FRAG_DEPTH];
    int   frag_accept[FRAG_DEPTH];
    int   frag_count;
    int   next_state;
    res_t owed_words[$];
    int   mismatches;
    int   words_seen;
    int   tokens_seen;
    int   finals_seen;
    int   errors_seen;

    function new();
      frag_count  = 0;
      next_state  = 0;
      mismatches  = 0;
      words_seen  = 0;
      tokens_seen = 0;
      finals_seen = 0;
      errors_seen = 0;
    endfunction

    function void owe(int from, int to, logic [7:0] label, bit eps, bit fin,
                      int left, logic [1:0] err, bit last);
      res_t w;
      w.from_state      = from[7:0];
      w.to_state        = to[7:0];
      w.edge_symbol     = label;
      w.is_epsilon      = eps;
      w.is_final_report = fin;
      w.fragments_left  = left[4:0];
      w.error_code      = err;
      w.last_of_run     = last;
      owed_words.push_back(w);
    endfunction

    function void owe_error(logic [1:0] err);
      owe(0, 0, 8'h00, 1'b0, 1'b0, 0, err, 1'b1);
    endfunction

    function bit two_states_free();
      return next_state + 2 <= MAX_STATES;
    endfunction

    // Apply one accepted token and queue the words it produces
    function void note_token(logic [2:0] kind, logic [7:0] label);
      int s;
      int l;
      int t;
      if (kind <= KIND_END) tokens_seen++;
      case (kind)
        KIND_SYM: begin
          // overflow is checked ahead of state exhaustion
          if (frag_count >= FRAG_DEPTH) owe_error(ERR_OVERFLOW);
          else if (!two_states_free()) owe_error(ERR_EXHAUSTED);
          else begin
            s = next_state;
            l = next_state + 1;
            next_state += 2;
            frag_start[frag_count]  = s;
            frag_accept[frag_count] = l;
            frag_count++;
            owe(s, l, label, 1'b0, 1'b0, 0, ERR_NONE, 1'b1);
          end
        end
        KIND_ALT: begin
          if (frag_count < 2) owe_error(ERR_UNDERFLOW);
          else if (!two_states_free()) owe_error(ERR_EXHAUSTED);
          else begin
            t = frag_count - 1;
            s = next_state;
            l = next_state + 1;
            next_state += 2;
            owe(s, frag_start[t], EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(s, frag_start[t-1], EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(frag_accept[t], l, EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(frag_accept[t-1], l, EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b1);
            frag_count       = t;
            frag_start[t-1]  = s;
            frag_accept[t-1] = l;
          end
        end
        KIND_CAT: begin
          if (frag_count < 2) owe_error(ERR_UNDERFLOW);
          else begin
            t = frag_count - 1;
            owe(frag_accept[t-1], frag_start[t], EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE,
                1'b1);
            frag_accept[t-1] = frag_accept[t];
            frag_count       = t;
          end
        end
        KIND_STAR: begin
          if (frag_count < 1) owe_error(ERR_UNDERFLOW);
          else if (!two_states_free()) owe_error(ERR_EXHAUSTED);
          else begin
            t = frag_count - 1;
            s = next_state;
            l = next_state + 1;
            next_state += 2;
            owe(s, frag_start[t], EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(s, l, EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(frag_accept[t], frag_start[t], EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b0);
            owe(frag_accept[t], l, EPS_LABEL, 1'b1, 1'b0, 0, ERR_NONE, 1'b1);
            frag_start[t]  = s;
            frag_accept[t] = l;
          end
        end
        KIND_END: begin
          if (frag_count < 1) owe_error(ERR_UNDERFLOW);
          else begin
            t = frag_count - 1;
            owe(frag_start[t], frag_accept[t], 8'h00, 1'b0, 1'b1, frag_count, ERR_NONE,
                1'b1);
            frag_count = 0;
            next_state = 0;
          end
        end
        default: ;  // unused kinds are dropped without a word
      endcase
    endfunction

    // Compare one accepted output word against the oldest owed word
    function void check_word(res_t got);
      res_t want;
      words_seen++;
      if (got.is_final_report) finals_seen++;
      if (got.error_code != ERR_NONE) errors_seen++;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: word %0d with nothing owed: from=%0d to=%0d sym=%02h eps=%0b fin=%0b left=%0d err=%0d last=%0b",
                   $realtime, words_seen, got.from_state, got.to_state, got.edge_symbol,
                   got.is_epsilon, got.is_final_report, got.fragments_left,
                   got.error_code, got.last_of_run);
        return;
      end
      want = owed_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: word %0d mismatch", $realtime, words_seen);
          $display("  expected from=%0d to=%0d sym=%02h eps=%0b fin=%0b left=%0d err=%0d last=%0b",
                   want.from_state, want.to_state, want.edge_symbol, want.is_epsilon,
                   want.is_final_report, want.fragments_left, want.error_code,
                   want.last_of_run);
          $display("  actual   from=%0d to=%0d sym=%02h eps=%0b fin=%0b left=%0d err=%0d last=%0b",
                   got.from_state, got.to_state, got.edge_symbol, got.is_epsilon,
                   got.is_final_report, got.fragments_left, got.error_code,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [2:0] in_token_kind = KIND_SYM;
  logic [7:0] in_symbol     = 8'h00;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_from_state;
  logic [7:0] out_to_state;
  logic [7:0] out_edge_symbol;
  logic       out_is_epsilon;
  logic       out_is_final_report;
  logic [4:0] out_fragments_left;
  logic [1:0] out_error_code;
  logic       out_last_of_run;

  res_t          out_word;
  nfa_scoreboard sb;
  logic [2:0]    kind_q[$];
  logic [7:0]    sym_q[$];
  int            counted_tokens = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            stall_cycles   = 0;
  int            send_pct[4]    = '{0, 69, 0, 8};
  int            recv_pct[4]    = '{0, 0, 69, 8};

  postfix_regex_to_nfa_builder_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_token_kind       (in_token_kind),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_from_state      (out_from_state),
    .out_to_state        (out_to_state),
    .out_edge_symbol     (out_edge_symbol),
    .out_is_epsilon      (out_is_epsilon),
    .out_is_final_report (out_is_final_report),
    .out_fragments_left  (out_fragments_left),
    .out_error_code      (out_error_code),
    .out_last_of_run     (out_last_of_run)
  );

  assign out_word = {out_from_state, out_to_state, out_edge_symbol, out_is_epsilon,
                     out_is_final_report, out_fragments_left, out_error_code,
                     out_last_of_run};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output word check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_word);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("postfix_regex_to_nfa_builder_core_tb: FAIL");
      $finish;
    end
  end

  function automatic void push_tok(logic [2:0] kind, logic [7:0] label);
    kind_q.push_back(kind);
    sym_q.push_back(label);
    if (kind <= KIND_END) counted_tokens++;
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(5))
      0: return CH_A;
      1: return CH_B;
      2: return CH_E;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random well-formed postfix expression; style 1 truncates it, style 2 adds a
  // stray operator. Always closed by an end token.
  function automatic void add_expression(int style);
    logic [2:0] body[$];
    int         depth;
    int         steps;
    int         pick;
    int         cut;
    depth = 0;
    steps = $urandom_range(1, 14);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (depth == 0 || (depth == 1 && pick >= 30) || (depth > 1 && depth < 6 && pick < 35))
        begin
        body.push_back(KIND_SYM);
        depth++;
      end else if (depth == 1 || pick < 50) begin
        body.push_back(KIND_STAR);
      end else if (pick < 75) begin
        body.push_back(KIND_ALT);
        depth--;
      end else begin
        body.push_back(KIND_CAT);
        depth--;
      end
    end
    while (depth > 1) begin
      body.push_back($urandom_range(1) ? KIND_ALT : KIND_CAT);
      depth--;
    end
    if (style == 1 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      repeat (cut) void'(body.pop_back());
    end
    if (style == 2)
      body.insert($urandom_range(body.size()), 3'($urandom_range(KIND_ALT, KIND_END)));
    foreach (body[i])
      push_tok(body[i], body[i] == KIND_SYM ? pick_symbol() : 8'($urandom_range(255)));
    push_tok(KIND_END, 8'($urandom_range(255)));
  endfunction

  task automatic build_stimulus();
    bit did_exhaust;
    bit did_overflow;
    int pick;
    did_exhaust  = 1'b0;
    did_overflow = 1'b0;

    // Directed: underflow on an empty stack, unused kinds, single-fragment
    // underflow, each operator, boundary labels, leftover fragments at end
    push_tok(KIND_END, 8'h00);
    push_tok(KIND_ALT, 8'hFF);
    push_tok(KIND_CAT, 8'h00);
    push_tok(KIND_STAR, 8'hFF);
    for (int k = KIND_END + 1; k < 8; k++) push_tok(3'(k), 8'h5A);
    push_tok(KIND_SYM, CH_A);
    push_tok(KIND_ALT, 8'h00);
    push_tok(KIND_CAT, 8'h00);
    push_tok(KIND_SYM, CH_B);
    push_tok(KIND_ALT, 8'h00);
    push_tok(KIND_STAR, 8'h00);
    push_tok(KIND_SYM, 8'h00);
    push_tok(KIND_CAT, 8'h00);
    push_tok(KIND_SYM, 8'hFF);
    push_tok(KIND_STAR, 8'h00);
    push_tok(KIND_ALT, 8'h00);
    push_tok(KIND_END, 8'h00);
    push_tok(KIND_SYM, CH_PLUS);
    push_tok(KIND_SYM, CH_DOT);
    push_tok(KIND_SYM, CH_STAR);
    push_tok(KIND_SYM, CH_E);
    push_tok(KIND_END, 8'hFF);

    // Random part
    while (counted_tokens < TOKEN_TARGET) begin
      if (!did_exhaust && counted_tokens >= 100) begin
        // fill the stack, then burn the state space with stars; overflow must
        // win over exhaustion on a full stack
        did_exhaust = 1'b1;
        push_tok(KIND_END, 8'h00);
        repeat (FRAG_DEPTH) push_tok(KIND_SYM, pick_symbol());
        push_tok(KIND_SYM, pick_symbol());
        repeat ((MAX_STATES - 2 * FRAG_DEPTH) / 2) push_tok(KIND_STAR, 8'($urandom_range(255)));
        push_tok(KIND_STAR, 8'h00);
        push_tok(KIND_SYM, pick_symbol());
        push_tok(KIND_ALT, 8'h00);
        repeat (FRAG_DEPTH - 1) push_tok(KIND_CAT, 8'($urandom_range(255)));
        push_tok(KIND_SYM, pick_symbol());
        push_tok(KIND_END, 8'h00);
      end else if (!did_overflow && counted_tokens >= 260) begin
        // overflow, then end with a full stack
        did_overflow = 1'b1;
        push_tok(KIND_END, 8'h00);
        repeat (FRAG_DEPTH + 1) push_tok(KIND_SYM, pick_symbol());
        push_tok(KIND_END, 8'h00);
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) add_expression(0);
        else if (pick < 80) add_expression(1);
        else if (pick < 85) add_expression(2);
        else repeat ($urandom_range(1, 4))
          push_tok(3'($urandom_range(7)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Drive one token word; returns at the falling edge after its acceptance
  task automatic send_token(logic [2:0] kind, logic [7:0] label);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_token_kind <= kind;
    in_symbol     <= label;
    do @(posedge clk); while (!in_ready);
    sb.note_token(kind, label);
    @(negedge clk);
  endtask

  initial begin
    int phase;
    sb = new();
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two passes over the four idle/stall phases
    for (int i = 0; i < kind_q.size(); i++) begin
      phase          = (i * 8 / kind_q.size()) % 4;
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      send_token(kind_q[i], sym_q[i]);
    end
    in_valid <= 1'b0;

    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d tokens over all operators, errors and idle phases",
             sb.tokens_seen);
    $display("checked %0d NFA words: %0d final reports, %0d error words, %0d mismatches",
             sb.words_seen, sb.finals_seen, sb.errors_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_words.size() == 0) begin
      $display("postfix_regex_to_nfa_builder_core_tb: PASS");
    end else begin
      $display("postfix_regex_to_nfa_builder_core_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/prnfa_pkg.sv
hdl/prnfa_front.sv
hdl/prnfa_back.sv
hdl/postfix_regex_to_nfa_builder_core.sv
sim/postfix_regex_to_nfa_builder_core_tb.sv
